// ===== design/gpds_pkg.sv =====
// Shared widths, register indexes and defaults for the grid point dedup and snap block.
package gpds_pkg;

	localparam int COORD_W     = 32;
	localparam int GRID_W      = 31;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int DIV_STEPS   = 32;
	localparam int DIV_CNT_W   = 5;
	localparam int TABLE_ENTRIES_DEF = 1024;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID = 2'd0,
		REG_CX   = 2'd1,
		REG_CY   = 2'd2,
		REG_CZ   = 2'd3
	} cfg_reg_t;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [GRID_W-1:0]         grid_t;

endpackage

// ===== design/gpds_ifs.sv =====
// Valid/ready channel interfaces for points in and snapped points out.
interface gpds_pt_if;
	logic                 valid;
	logic                 ready;
	logic                 kind;
	gpds_pkg::coord_t     point_x;
	gpds_pkg::coord_t     point_y;
	gpds_pkg::coord_t     point_z;

	modport source (output valid, kind, point_x, point_y, point_z, input ready);
	modport sink   (input valid, kind, point_x, point_y, point_z, output ready);
endinterface

interface gpds_res_if;
	logic                 valid;
	logic                 ready;
	gpds_pkg::coord_t     out_x;
	gpds_pkg::coord_t     out_y;
	gpds_pkg::coord_t     out_z;
	logic                 table_overflow;

	modport source (output valid, out_x, out_y, out_z, table_overflow, input ready);
	modport sink   (input valid, out_x, out_y, out_z, table_overflow, output ready);
endinterface

// ===== design/gpds_div.sv =====
// Restoring radix-2 divider: 32-bit unsigned dividend by 31-bit divisor, one bit per cycle.
module gpds_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [gpds_pkg::COORD_W-1:0]    dividend,
	input  gpds_pkg::grid_t                 divisor,
	output logic                            done,
	output logic [gpds_pkg::COORD_W-1:0]    quo,
	output gpds_pkg::grid_t                 rem
);

	logic                             busy_q;
	logic                             done_q;
	logic [gpds_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [gpds_pkg::COORD_W-1:0]     quo_q;
	gpds_pkg::grid_t                  rem_q;
	gpds_pkg::grid_t                  dvs_q;
	logic [gpds_pkg::COORD_W-1:0]     shifted;
	logic [gpds_pkg::COORD_W:0]       diff;

	assign shifted = {rem_q, quo_q[gpds_pkg::COORD_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == gpds_pkg::DIV_CNT_W'(gpds_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the dividend shifts out of quo_q while quotient bits shift in.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[gpds_pkg::COORD_W]) begin
				rem_q <= diff[gpds_pkg::GRID_W-1:0];
				quo_q <= {quo_q[gpds_pkg::COORD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[gpds_pkg::GRID_W-1:0];
				quo_q <= {quo_q[gpds_pkg::COORD_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start) else $error("divider restarted while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("divider done without a run");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && dvs_q != '0 |-> rem_q < dvs_q) else $error("remainder not below divisor");

endmodule

// ===== design/grid_point_dedup_snap.sv =====
// Top level: voxel-grid point reduction with a linear-probing seen-cell table.
//
//  channel   dir   handshake      payload
//  pts       in    valid/ready    kind, point_x, point_y, point_z
//  snapped   out   valid/ready    out_x, out_y, out_z, table_overflow
//  cfg       in    cfg_we         cfg_index, cfg_wdata (write only)
//
// A point item holds the input while three parallel 32-step dividers
// run, then each probe of the table memory passes through a read state
// and a compare state; a result that finds no match leaves through the
// emit state. A zero grid size passes a point straight to the emit state.
// After reset and after every clear item the block sweeps the table memory,
// one entry per cycle (TABLE_ENTRIES entries, 1024 by default), and accepts
// no item meanwhile. A result waits in an output register, so the input
// side stays open while the output stalls; a second result then waits in
// the emit state until the register frees.
module grid_point_dedup_snap #(
	parameter int TABLE_ENTRIES = gpds_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	gpds_pt_if.sink                           pts,
	gpds_res_if.source                        snapped,
	input  logic                              cfg_we,
	input  logic [gpds_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gpds_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_DIV, ST_RD, ST_CMP, ST_EMIT
	} state_t;

	typedef struct packed {
		logic                          vld;
		logic [gpds_pkg::COORD_W-1:0]  cx;
		logic [gpds_pkg::COORD_W-1:0]  cy;
		logic [gpds_pkg::COORD_W-1:0]  cz;
	} entry_t;

	// Configuration registers.
	gpds_pkg::grid_t   grid_q;
	gpds_pkg::coord_t  cen_x_q, cen_y_q, cen_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q  <= '0;
			cen_x_q <= '0;
			cen_y_q <= '0;
			cen_z_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gpds_pkg::REG_GRID: grid_q  <= cfg_wdata[gpds_pkg::GRID_W-1:0];
				gpds_pkg::REG_CX:   cen_x_q <= cfg_wdata;
				gpds_pkg::REG_CY:   cen_y_q <= cfg_wdata;
				gpds_pkg::REG_CZ:   cen_z_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	state_t            state_q;
	logic [AW-1:0]     sweep_q;
	logic [AW-1:0]     slot_q;
	logic [AW-1:0]     probe_q;
	gpds_pkg::coord_t  px_q, py_q, pz_q;
	entry_t            cell_q;
	gpds_pkg::coord_t  sx_q, sy_q, sz_q;
	logic              ovf_q;
	logic              out_valid_q;
	gpds_pkg::coord_t  ox_q, oy_q, oz_q;
	logic              oovf_q;

	logic              acc;
	logic              div_start;
	logic              emit_ok;
	logic              done_x, done_y, done_z;
	logic [gpds_pkg::COORD_W-1:0] qx, qy, qz;
	gpds_pkg::grid_t   rx, ry, rz;
	entry_t            rd_q;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	entry_t            mem_wd;
	entry_t            cell_new;
	logic              hit;

	assign pts.ready = (state_q == ST_IDLE);
	assign acc       = pts.valid && pts.ready;
	assign div_start = acc && !pts.kind && (grid_q != '0);
	assign emit_ok   = (state_q == ST_EMIT) && (!out_valid_q || snapped.ready);

	function automatic logic [gpds_pkg::COORD_W-1:0] mag(input gpds_pkg::coord_t p);
		mag = p[gpds_pkg::COORD_W-1] ? (~p + 1'b1) : p;
	endfunction

	// Floor cell of p / g from the magnitude quotient and remainder.
	function automatic logic [gpds_pkg::COORD_W-1:0] cell_of(
		input gpds_pkg::coord_t p,
		input logic [gpds_pkg::COORD_W-1:0] q,
		input gpds_pkg::grid_t r);
		if (!p[gpds_pkg::COORD_W-1])
			cell_of = q;
		else if (r != '0)
			cell_of = ~q;
		else
			cell_of = ~q + 1'b1;
	endfunction

	// Snap away from the center. Truncation toward zero times g is p -+ r;
	// the ceiling of a positive point or the floor of a negative one with a
	// nonzero remainder moves one more cell outward. No multiply is needed.
	function automatic gpds_pkg::coord_t snap(
		input gpds_pkg::coord_t p,
		input gpds_pkg::coord_t c,
		input gpds_pkg::grid_t r,
		input gpds_pkg::grid_t g);
		logic signed [33:0] ps, rs, gs, res;
		logic neg, up;
		ps  = {{2{p[31]}}, p};
		rs  = {3'b000, r};
		gs  = {3'b000, g};
		neg = p[31];
		up  = (p >= c);
		res = neg ? ps + rs : ps - rs;
		if (r != '0 && up && !neg)
			res = res + gs;
		else if (r != '0 && !up && neg)
			res = res - gs;
		if (res[33:31] == 3'b000 || res[33:31] == 3'b111)
			snap = res[31:0];
		else if (res[33])
			snap = 32'sh8000_0000;
		else
			snap = 32'sh7fff_ffff;
	endfunction

	function automatic logic [AW-1:0] hash(input entry_t e);
		logic [AW-1:0] h;
		h = e.cx[AW-1:0] ^ e.cy[AW-1:0] ^ e.cz[AW-1:0];
		hash = (h > LAST) ? h - AW'(TABLE_ENTRIES) : h;
	endfunction

	gpds_div u_div_x (.clk, .arst_n, .start(div_start), .dividend(mag(pts.point_x)),
		.divisor(grid_q), .done(done_x), .quo(qx), .rem(rx));
	gpds_div u_div_y (.clk, .arst_n, .start(div_start), .dividend(mag(pts.point_y)),
		.divisor(grid_q), .done(done_y), .quo(qy), .rem(ry));
	gpds_div u_div_z (.clk, .arst_n, .start(div_start), .dividend(mag(pts.point_z)),
		.divisor(grid_q), .done(done_z), .quo(qz), .rem(rz));

	always_comb begin
		cell_new.vld = 1'b1;
		cell_new.cx  = cell_of(px_q, qx, rx);
		cell_new.cy  = cell_of(py_q, qy, ry);
		cell_new.cz  = cell_of(pz_q, qz, rz);
	end

	assign hit = rd_q.vld && rd_q.cx == cell_q.cx && rd_q.cy == cell_q.cy
		&& rd_q.cz == cell_q.cz;

	// The table memory is written by the clearing sweep and by the insert of a
	// new cell into the empty slot that the probe just read.
	always_comb begin
		mem_we = (state_q == ST_CLEAR) || (state_q == ST_CMP && !rd_q.vld);
		mem_wa = (state_q == ST_CLEAR) ? sweep_q : slot_q;
		mem_wd = cell_q;
		mem_wd.vld = (state_q != ST_CLEAR);
	end

	entry_t mem [TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rd_q <= mem[slot_q];
	end

	// Payload registers that need no reset.
	always_ff @(posedge clk) begin
		if (acc) begin
			px_q <= pts.point_x;
			py_q <= pts.point_y;
			pz_q <= pts.point_z;
			sx_q <= pts.point_x;
			sy_q <= pts.point_y;
			sz_q <= pts.point_z;
		end else if (state_q == ST_DIV && done_x) begin
			cell_q <= cell_new;
			sx_q   <= snap(px_q, cen_x_q, rx, grid_q);
			sy_q   <= snap(py_q, cen_y_q, ry, grid_q);
			sz_q   <= snap(pz_q, cen_z_q, rz, grid_q);
		end
	end

	// Sequencer with the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			sweep_q     <= '0;
			slot_q      <= '0;
			probe_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			ox_q        <= '0;
			oy_q        <= '0;
			oz_q        <= '0;
			oovf_q      <= 1'b0;
		end else begin
			if (emit_ok) begin
				out_valid_q <= 1'b1;
				ox_q        <= sx_q;
				oy_q        <= sy_q;
				oz_q        <= sz_q;
				oovf_q      <= ovf_q;
			end else if (snapped.valid && snapped.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					sweep_q <= (sweep_q == LAST) ? '0 : sweep_q + 1'b1;
					if (sweep_q == LAST)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (acc) begin
						ovf_q <= 1'b0;
						priority if (pts.kind)
							state_q <= ST_CLEAR;
						else if (grid_q == '0)
							state_q <= ST_EMIT;
						else
							state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (done_x) begin
						slot_q  <= hash(cell_new);
						probe_q <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_CMP;
				ST_CMP: begin
					priority if (!rd_q.vld)
						state_q <= ST_EMIT;
					else if (hit)
						state_q <= ST_IDLE;
					else if (probe_q == LAST) begin
						ovf_q   <= 1'b1;
						state_q <= ST_EMIT;
					end else begin
						probe_q <= probe_q + 1'b1;
						slot_q  <= (slot_q == LAST) ? '0 : slot_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_EMIT: begin
					if (emit_ok)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign snapped.valid          = out_valid_q;
	assign snapped.out_x          = ox_q;
	assign snapped.out_y          = oy_q;
	assign snapped.out_z          = oz_q;
	assign snapped.table_overflow = oovf_q;

	a_lanes_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		done_x |-> done_y && done_z) else $error("divider lanes out of step");
	a_insert_empty_only: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && state_q != ST_CLEAR |-> state_q == ST_CMP && !rd_q.vld)
		else $error("table write outside an empty-slot insert");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit_ok |-> !out_valid_q || snapped.ready) else $error("pending result overwritten");
	a_closed_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !pts.ready) else $error("item accepted during table sweep");
	a_overflow_full_probe: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP && rd_q.vld && !hit && probe_q == LAST |=> ovf_q)
		else $error("full probe without overflow flag");

endmodule
